// File: design/stbs_pkg.sv
package stbs_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 9;
  localparam int RANGE_W         = 9;
  localparam int ENTRY_IDX_W     = 8;
  localparam int DATA_W          = 32;
  localparam int MATCH_IDX_W     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_END   = 1'b1;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef struct packed {
    logic                     command;
    logic [ENTRY_IDX_W-1:0]   entry_index;
    logic signed [DATA_W-1:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic                   found;
    logic [MATCH_IDX_W-1:0] match_index;
  } out_item_t;

  typedef struct packed {
    logic wr_en;
    logic load;
    logic step;
    logic res_set;
    logic res_found;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic init_empty;
    logic hit;
    logic next_empty;
  } dp_sts_t;

endpackage

// File: design/stbs_datapath.sv
module stbs_datapath #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [stbs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [stbs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  stbs_pkg::in_item_t                   in_data,
  input  stbs_pkg::ctrl_cmd_t                  cmd,
  output stbs_pkg::dp_sts_t                    sts,
  output stbs_pkg::out_item_t                  out_data
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int BND_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (BND_W > stbs_pkg::RANGE_W) ? BND_W : stbs_pkg::RANGE_W;

  logic [stbs_pkg::DATA_W-1:0]        mem [TABLE_DEPTH];
  logic signed [stbs_pkg::DATA_W-1:0] rd_data_r;
  logic signed [stbs_pkg::DATA_W-1:0] key_r;
  logic [stbs_pkg::RANGE_W-1:0]       range_start_r;
  logic [stbs_pkg::RANGE_W-1:0]       range_end_r;
  logic [BND_W-1:0]                   lo_r;
  logic [BND_W-1:0]                   hi_r;
  logic [IDX_W-1:0]                   mid_r;
  logic                               res_found_r;
  logic [stbs_pkg::MATCH_IDX_W-1:0]   res_idx_r;
  stbs_pkg::out_item_t                out_data_r;

  logic [CMP_W-1:0] start_w;
  logic [CMP_W-1:0] end_w;
  logic [CMP_W-1:0] depth_w;
  logic [CMP_W-1:0] hi0_w;
  logic [CMP_W-1:0] span0_w;
  logic [CMP_W-1:0] mid0_w;
  logic [CMP_W-1:0] wr_idx_w;
  logic [CMP_W-1:0] mid_ext_w;
  logic             wr_ok;
  logic             go_right;
  logic [BND_W-1:0] mid_b;
  logic [BND_W-1:0] mid_p1;
  logic [BND_W-1:0] right_mid;
  logic [BND_W-1:0] left_mid;
  logic             right_empty;
  logic             left_empty;
  logic [BND_W-1:0] lo_nxt;
  logic [BND_W-1:0] hi_nxt;
  logic [IDX_W-1:0] mid_nxt;
  logic [IDX_W-1:0] rd_addr;

  always_comb begin
    start_w   = CMP_W'(range_start_r);
    end_w     = CMP_W'(range_end_r);
    depth_w   = CMP_W'(TABLE_DEPTH);
    hi0_w     = (end_w > depth_w) ? depth_w : end_w;
    span0_w   = hi0_w - start_w;
    mid0_w    = start_w + (span0_w >> 1);
    wr_idx_w  = CMP_W'(in_data.entry_index);
    wr_ok     = wr_idx_w < depth_w;
    mid_ext_w = CMP_W'(mid_r);

    go_right    = key_r > rd_data_r;
    mid_b       = BND_W'(mid_r);
    mid_p1      = mid_b + BND_W'(1);
    right_mid   = mid_p1 + ((hi_r - mid_p1) >> 1);
    left_mid    = lo_r + ((mid_b - lo_r) >> 1);
    right_empty = mid_p1 >= hi_r;
    left_empty  = lo_r >= mid_b;

    lo_nxt  = go_right ? mid_p1 : lo_r;
    hi_nxt  = go_right ? hi_r : mid_b;
    mid_nxt = go_right ? right_mid[IDX_W-1:0] : left_mid[IDX_W-1:0];
    rd_addr = cmd.load ? mid0_w[IDX_W-1:0] : mid_nxt;

    sts.init_empty = start_w >= hi0_w;
    sts.hit        = rd_data_r == key_r;
    sts.next_empty = go_right ? right_empty : left_empty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_start_r <= '0;
      range_end_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        stbs_pkg::REG_RANGE_START: range_start_r <= cfg_wdata;
        stbs_pkg::REG_RANGE_END:   range_end_r   <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_ok) begin
      mem[wr_idx_w[IDX_W-1:0]] <= in_data.data_value;
    end
    if (cmd.load || cmd.step) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_data.data_value;
      lo_r  <= start_w[BND_W-1:0];
      hi_r  <= hi0_w[BND_W-1:0];
      mid_r <= mid0_w[IDX_W-1:0];
    end else if (cmd.step) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      mid_r <= mid_nxt;
    end
    if (cmd.res_set) begin
      res_found_r <= cmd.res_found;
      res_idx_r   <= cmd.res_found ? mid_ext_w[stbs_pkg::MATCH_IDX_W-1:0] : '0;
    end
    if (cmd.out_load) begin
      out_data_r.found       <= res_found_r;
      out_data_r.match_index <= res_idx_r;
    end
  end

  assign out_data = out_data_r;

endmodule

// File: design/stbs_ctrl.sv
module stbs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_command,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  input  stbs_pkg::dp_sts_t   sts,
  output stbs_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_command == stbs_pkg::CMD_WRITE) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.load = 1'b1;
            if (sts.init_empty) begin
              cmd.res_set = 1'b1;
              state_nxt   = S_DONE;
            end else begin
              state_nxt = S_PROBE;
            end
          end
        end
      end
      S_PROBE: begin
        priority if (sts.hit) begin
          cmd.res_set   = 1'b1;
          cmd.res_found = 1'b1;
          state_nxt     = S_DONE;
        end else if (sts.next_empty) begin
          cmd.res_set = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

endmodule

// File: design/sorted_table_binary_search_unit.sv
// Binary search over a table of signed 32-bit entries written in ascending order. A write
// transaction produces no result and leaves the input ready for the next transaction. A
// search transaction probes the table once per cycle through the single registered read port
// of the table memory, up to floor(log2(TABLE_DEPTH)) + 1 probes, or makes no probe when the
// configured range is empty, and then moves its result into the output register once the
// previous result has been taken from it; the input is held off until the result is moved.
// The user must write the range registers through the cfg port only while no search is in
// flight; the block itself does not enforce this. A range end beyond the table is clipped to
// the table depth.
module sorted_table_binary_search_unit #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [stbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stbs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  stbs_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output stbs_pkg::out_item_t             out_data
);

  stbs_pkg::ctrl_cmd_t cmd;
  stbs_pkg::dp_sts_t   sts;

  stbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_ready   (in_ready),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .sts        (sts),
    .cmd        (cmd)
  );

  stbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

// File: design/stbs_checker.sv
module stbs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            cfg_wr_en,
  input logic [stbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [stbs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input logic                            in_valid,
  input logic                            in_ready,
  input stbs_pkg::in_item_t              in_data,
  input logic                            out_valid,
  input logic                            out_ready,
  input stbs_pkg::out_item_t             out_data
);

  // A result that is not taken stays offered unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result transaction dropped or changed while stalled");

  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.match_index == '0)
    else $error("nonzero index on a miss");

  // A table write completes in the cycle it is accepted.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.command == stbs_pkg::CMD_WRITE |=> in_ready)
    else $error("input stalled after a write transaction");

  // A search holds off the input until its result has been produced.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.command == stbs_pkg::CMD_SEARCH |=> !in_ready)
    else $error("input accepted during a search");

endmodule

bind sorted_table_binary_search_unit stbs_checker u_stbs_checker (.*);
